@@ hw/rtl/sorted_unique_set_table_top_defines.svh @@
// ----------------------------------------------------------------------------
// Sorted unique set table assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_SET_TABLE_TOP_DEFINES_SVH
`define SORTED_UNIQUE_SET_TABLE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SUST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SUST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sust_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted unique set table package
// Types, codes and widths shared by the set table modules.
// ----------------------------------------------------------------------------
package sust_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_INSERTED  = 3'd0,
        STS_DUPLICATE = 3'd1,
        STS_FULL      = 3'd2,
        STS_DELETED   = 3'd3,
        STS_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_RESULT
    } t_state;

    // Signed order of two keys.
    function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

@@ hw/rtl/sust_if.sv @@
// ----------------------------------------------------------------------------
// Sorted unique set table channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface sust_in_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic signed [sust_pkg::KEY_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sust_out_if;
    logic                            valid;
    logic                            ready;
    logic [sust_pkg::STATUS_W-1:0]   status;
    logic [sust_pkg::COUNT_W-1:0]    count;

    modport source (output valid, output status, output count, input ready);
    modport sink   (input valid, input status, input count, output ready);
endinterface

@@ hw/rtl/sust_mem.sv @@
// ----------------------------------------------------------------------------
// Sorted unique set table storage
// Key table with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sust_mem #(
    parameter int DEPTH = sust_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [sust_pkg::KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [sust_pkg::KEY_W-1:0] o_rdata
);

    logic [sust_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic [sust_pkg::KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sust_seq.sv @@
// ----------------------------------------------------------------------------
// Sorted unique set table sequencer
// Walks the table one entry per cycle to search, then shifts entries up or
// down to open or close a slot, and registers the result beat.
// ----------------------------------------------------------------------------
`include "sorted_unique_set_table_top_defines.svh"

module sust_seq #(
    parameter int CAPACITY = sust_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sust_in_if.sink                    i_in,
    sust_out_if.source                 o_out,
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output logic [sust_pkg::KEY_W-1:0] o_wdata,
    output logic [AW-1:0]              o_raddr,
    input  logic [sust_pkg::KEY_W-1:0] i_rdata
);

    sust_pkg::t_state           r_state,  n_state;
    sust_pkg::t_op              r_op,     n_op;
    logic [sust_pkg::KEY_W-1:0] r_key,    n_key;
    logic [CW-1:0]              r_idx,    n_idx;
    logic [CW-1:0]              r_pos,    n_pos;
    logic [CW-1:0]              r_count,  n_count;
    sust_pkg::t_status          r_status, n_status;
    logic                       r_out_valid, n_out_valid;
    logic [sust_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [sust_pkg::COUNT_W-1:0]  r_out_count,  n_out_count;

    logic          w_in_fire;
    logic          w_less;
    logic          w_eq;
    logic          w_last;
    logic          w_hit;
    logic          w_full;
    logic          w_load;
    logic [CW-1:0] w_found;
    logic [CW-1:0] w_idx_inc;

    assign w_in_fire = i_in.valid && i_in.ready;
    assign w_less    = sust_pkg::key_less(i_rdata, r_key);
    assign w_eq      = (i_rdata == r_key);
    assign w_idx_inc = r_idx + 1'b1;
    assign w_last    = (w_idx_inc >= r_count);
    assign w_found   = w_less ? r_count : r_idx;
    assign w_hit     = !w_less && w_eq;
    assign w_full    = (r_count == CW'(CAPACITY));
    assign w_load    = (r_state == sust_pkg::ST_RESULT) && (!r_out_valid || o_out.ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sust_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    if (r_count != '0) begin
                        n_state = sust_pkg::ST_SEARCH;
                    end else if (i_in.opcode == sust_pkg::OP_INSERT) begin
                        n_state = sust_pkg::ST_SHIFT_UP;
                    end else begin
                        n_state = sust_pkg::ST_RESULT;
                    end
                end
            end
            sust_pkg::ST_SEARCH: begin
                if (!(w_less && !w_last)) begin
                    if (r_op == sust_pkg::OP_INSERT) begin
                        n_state = (w_hit || w_full) ? sust_pkg::ST_RESULT
                                                    : sust_pkg::ST_SHIFT_UP;
                    end else if (w_hit && ((w_found + 1'b1) < r_count)) begin
                        n_state = sust_pkg::ST_SHIFT_DN;
                    end else begin
                        n_state = sust_pkg::ST_RESULT;
                    end
                end
            end
            sust_pkg::ST_SHIFT_UP: begin
                if (r_idx == r_pos) begin
                    n_state = sust_pkg::ST_RESULT;
                end
            end
            sust_pkg::ST_SHIFT_DN: begin
                if ((w_idx_inc + 1'b1) >= r_count) begin
                    n_state = sust_pkg::ST_RESULT;
                end
            end
            sust_pkg::ST_RESULT: begin
                if (w_load) begin
                    n_state = sust_pkg::ST_IDLE;
                end
            end
            default: n_state = sust_pkg::ST_IDLE;
        endcase
    end

    // Datapath and table port control
    always_comb begin
        n_op         = r_op;
        n_key        = r_key;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_count      = r_count;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        o_we         = 1'b0;
        o_waddr      = AW'(r_idx);
        o_wdata      = i_rdata;
        o_raddr      = '0;
        case (r_state)
            sust_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    n_op     = sust_pkg::t_op'(i_in.opcode);
                    n_key    = i_in.value;
                    n_idx    = '0;
                    n_pos    = '0;
                    n_status = (i_in.opcode == sust_pkg::OP_INSERT) ? sust_pkg::STS_INSERTED
                                                                     : sust_pkg::STS_NOT_FOUND;
                end
            end
            sust_pkg::ST_SEARCH: begin
                if (w_less && !w_last) begin
                    n_idx   = w_idx_inc;
                    o_raddr = AW'(w_idx_inc);
                end else begin
                    n_pos = w_found;
                    if (r_op == sust_pkg::OP_INSERT) begin
                        if (w_hit) begin
                            n_status = sust_pkg::STS_DUPLICATE;
                        end else if (w_full) begin
                            n_status = sust_pkg::STS_FULL;
                        end else begin
                            // Start the upward shift at the top slot; the search
                            // ran at least one entry, so the count is not zero.
                            n_status = sust_pkg::STS_INSERTED;
                            n_idx    = r_count;
                            o_raddr  = AW'(r_count - 1'b1);
                        end
                    end else begin
                        n_status = w_hit ? sust_pkg::STS_DELETED : sust_pkg::STS_NOT_FOUND;
                        n_idx    = w_found;
                        if ((w_found + 1'b1) < r_count) begin
                            o_raddr = AW'(w_found + 1'b1);
                        end
                    end
                end
            end
            sust_pkg::ST_SHIFT_UP: begin
                o_we = 1'b1;
                if (r_idx == r_pos) begin
                    o_wdata = r_key;
                end else begin
                    n_idx = r_idx - 1'b1;
                    if (r_idx >= CW'(2)) begin
                        o_raddr = AW'(r_idx - CW'(2));
                    end
                end
            end
            sust_pkg::ST_SHIFT_DN: begin
                o_we  = 1'b1;
                n_idx = w_idx_inc;
                if ((w_idx_inc + 1'b1) < r_count) begin
                    o_raddr = AW'(w_idx_inc + 1'b1);
                end
            end
            sust_pkg::ST_RESULT: begin
                if (w_load) begin
                    case (r_status)
                        sust_pkg::STS_INSERTED: n_count = r_count + 1'b1;
                        sust_pkg::STS_DELETED:  n_count = r_count - 1'b1;
                        default:                n_count = r_count;
                    endcase
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_count  = sust_pkg::COUNT_W'(n_count);
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sust_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign i_in.ready   = (r_state == sust_pkg::ST_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.count  = r_out_count;

    `SUST_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `SUST_ASSERT_NEXT(a_busy_after_accept, w_in_fire, !i_in.ready, "ready right after accept")
    `SUST_ASSERT_NEXT(a_count_held, r_state != sust_pkg::ST_RESULT, $stable(r_count), "count moved mid-operation")
    `SUST_ASSERT_NEXT(a_insert_grows, w_load && (r_status == sust_pkg::STS_INSERTED), r_count == $past(r_count) + 1'b1, "insert did not grow count")
    `SUST_ASSERT_SAME(a_no_write_idle, (r_state == sust_pkg::ST_IDLE) || (r_state == sust_pkg::ST_RESULT), !o_we, "table written outside a shift")

endmodule

@@ hw/rtl/sorted_unique_set_table_top.sv @@
// From an accepted request beat until its result beat is valid, the sequencer searches the
// stored entries, shifts entries, places the new key on an insert, and loads the result
// register. A request is taken only in the idle cycle after the previous result is registered.
// Reset clears the entry count and handshake state; table contents stay undefined.
// ----------------------------------------------------------------------------
// Sorted unique set table top level
// Bounded ascending set of distinct signed keys with insert and delete requests.
// ----------------------------------------------------------------------------
module sorted_unique_set_table_top #(
    parameter int CAPACITY = sust_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sust_in_if.sink     i_in,
    sust_out_if.source  o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [sust_pkg::KEY_W-1:0] w_wdata;
    logic [AW-1:0]              w_raddr;
    logic [sust_pkg::KEY_W-1:0] w_rdata;

    sust_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sust_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata)
    );

endmodule
